// ----- hdl/two_fifo_lazy_promotion_cache_policy_unit_defines.svh -----
// Assertion macros for the cache policy unit.
`ifndef TWO_FIFO_LAZY_PROMOTION_CACHE_POLICY_UNIT_DEFINES_SVH
`define TWO_FIFO_LAZY_PROMOTION_CACHE_POLICY_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define TFLP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cache policy assertion failed");
`define TFLP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cache policy assertion failed");
`else
`define TFLP_ASSERT_IMP(lbl, ante, cons)
`define TFLP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- hdl/tflp_pkg.sv -----
// Shared types and constants of the cache policy unit.
package tflp_pkg;

    localparam int CAPACITY  = 4096;
    localparam int SLOT_W    = $clog2(CAPACITY);
    localparam int CNT_W     = SLOT_W + 1;
    localparam int BN_W      = 48;
    localparam int PCT_W     = 7;
    localparam int OP_W      = 2;
    localparam int ST_W      = 3;
    localparam int CFG_IDX_W = 1;
    localparam int SHARE_W   = CNT_W + PCT_W;

    localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
    localparam logic [PCT_W-1:0] PCT_RESET = 7'd10;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_ACCESS = 2'd1,
        OP_INVAL  = 2'd2,
        OP_RSVD   = 2'd3
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_HIT         = 3'd0,
        ST_MISS_INS    = 3'd1,
        ST_NOT_FOUND   = 3'd2,
        ST_RANGE       = 3'd3,
        ST_INVALIDATED = 3'd4,
        ST_NOT_PRESENT = 3'd5,
        ST_NO_FREE     = 3'd6
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEV_BLOCKS = 1'd0,
        REG_HOT_PCT    = 1'd1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DECIDE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_ALLOC_RD,
        S_ALLOC,
        S_SHRINK,
        S_POP_RD,
        S_POP,
        S_OUT_ONE,
        S_OUT_FIRST,
        S_OUT_EV
    } state_t;

    typedef struct packed {
        logic    init_wr;
        logic    idx_clr;
        logic    idx_inc;
        logic    latch_in;
        logic    hit_upd;
        logic    alloc;
        logic    hot_pop;
        logic    cold_pop;
        logic    ent_rd_pop;
        logic    pop_eval;
        logic    set_status;
        status_t status;
        logic    sel_ev;
        logic    out_last;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic out_range;
        logic match;
        logic idx_last;
        logic free_empty;
        logic hot_go;
        logic cold_go;
        logic accessed;
    } sts_t;

endpackage

// ----- hdl/tflp_datapath.sv -----
// Tag store, slot queues, configuration and result registers.
module tflp_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tflp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tflp_pkg::BN_W-1:0]      cfg_data,
    input  logic [tflp_pkg::OP_W-1:0]      opcode,
    input  logic [tflp_pkg::BN_W-1:0]      block_number,
    input  tflp_pkg::cmd_t                 cmd,
    output tflp_pkg::sts_t                 sts,
    output logic                           kind,
    output logic [tflp_pkg::ST_W-1:0]      status,
    output logic [tflp_pkg::SLOT_W-1:0]    slot,
    output logic [tflp_pkg::BN_W-1:0]      result_block,
    output logic                           last
);
    import tflp_pkg::*;

    localparam int ENT_W = BN_W + 2;

    logic [ENT_W-1:0]  ent_mem [CAPACITY];
    logic [SLOT_W-1:0] free_mem [CAPACITY];
    logic [SLOT_W-1:0] hot_mem [CAPACITY];
    logic [SLOT_W-1:0] cold_mem [CAPACITY];

    logic [BN_W-1:0]   dev_blocks_reg;
    logic [PCT_W-1:0]  hot_pct_reg;
    logic [OP_W-1:0]   op_reg;
    logic [BN_W-1:0]   bn_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic [ENT_W-1:0]  ent_rd_reg;
    logic [SLOT_W-1:0] free_rd_reg, hot_rd_reg, cold_rd_reg;
    logic [SLOT_W-1:0] free_head_reg, hot_head_reg, cold_head_reg;
    logic [CNT_W-1:0]  free_count_reg, hot_count_reg, cold_count_reg;
    logic              from_hot_reg;
    logic [SLOT_W-1:0] pop_slot_reg;
    logic [ST_W-1:0]   res_status_reg;
    logic [SLOT_W-1:0] res_slot_reg, ev_slot_reg;
    logic [BN_W-1:0]   res_block_reg, ev_block_reg;

    logic [SLOT_W-1:0] q_data, ent_raddr, ent_waddr;
    logic [ENT_W-1:0]  ent_wdata;
    logic              ent_we;
    logic              rd_valid, rd_acc;
    logic [BN_W-1:0]   rd_tag;
    logic [PCT_W-1:0]  hp, cp;
    logic [SHARE_W-1:0] hot_share, cold_share, hot_thr, cold_thr;
    logic              free_push, cold_push, hot_push;

    assign rd_valid = ent_rd_reg[ENT_W-1];
    assign rd_acc   = ent_rd_reg[ENT_W-2];
    assign rd_tag   = ent_rd_reg[BN_W-1:0];
    assign q_data   = from_hot_reg ? hot_rd_reg : cold_rd_reg;
    assign ent_raddr = cmd.ent_rd_pop ? q_data : idx_reg;

    assign hp = (hot_pct_reg > PCT_FULL) ? PCT_FULL : hot_pct_reg;
    assign cp = PCT_FULL - hp;
    assign hot_share  = SHARE_W'(hot_count_reg) * SHARE_W'(PCT_FULL);
    assign cold_share = SHARE_W'(cold_count_reg) * SHARE_W'(PCT_FULL);
    assign hot_thr    = SHARE_W'(hp) << SLOT_W;
    assign cold_thr   = SHARE_W'(cp) << SLOT_W;

    assign hot_push  = cmd.alloc && (hot_count_reg != CNT_W'(CAPACITY));
    assign cold_push = cmd.pop_eval && rd_acc && (cold_count_reg != CNT_W'(CAPACITY));
    assign free_push = cmd.pop_eval && !rd_acc && (free_count_reg != CNT_W'(CAPACITY));

    always_comb
    begin
        ent_we    = 1'b1;
        ent_waddr = idx_reg;
        ent_wdata = '0;
        if (cmd.init_wr)
        begin
            ent_waddr = idx_reg;
            ent_wdata = '0;
        end
        else if (cmd.hit_upd)
        begin
            ent_waddr = idx_reg;
            if (op_reg == OP_INVAL)
                ent_wdata = {1'b0, rd_acc, rd_tag};
            else
                ent_wdata = {1'b1, 1'b1, rd_tag};
        end
        else if (cmd.alloc)
        begin
            ent_waddr = free_rd_reg;
            ent_wdata = {1'b1, 1'b0, bn_reg};
        end
        else if (cmd.pop_eval)
        begin
            ent_waddr = pop_slot_reg;
            ent_wdata = {rd_acc & rd_valid, 1'b0, rd_tag};
        end
        else
        begin
            ent_we = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
            ent_mem[ent_waddr] <= ent_wdata;
        ent_rd_reg <= ent_mem[ent_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init_wr)
            free_mem[idx_reg] <= idx_reg;
        else if (free_push)
            free_mem[free_head_reg + free_count_reg[SLOT_W-1:0]] <= pop_slot_reg;
        free_rd_reg <= free_mem[free_head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (hot_push)
            hot_mem[hot_head_reg + hot_count_reg[SLOT_W-1:0]] <= free_rd_reg;
        hot_rd_reg <= hot_mem[hot_head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cold_push)
            cold_mem[cold_head_reg + cold_count_reg[SLOT_W-1:0]] <= pop_slot_reg;
        cold_rd_reg <= cold_mem[cold_head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_blocks_reg <= '0;
            hot_pct_reg    <= PCT_RESET;
            idx_reg        <= '0;
            free_head_reg  <= '0;
            free_count_reg <= CNT_W'(CAPACITY);
            hot_head_reg   <= '0;
            hot_count_reg  <= '0;
            cold_head_reg  <= '0;
            cold_count_reg <= '0;
            from_hot_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DEV_BLOCKS: dev_blocks_reg <= cfg_data;
                    REG_HOT_PCT:    hot_pct_reg    <= cfg_data[PCT_W-1:0];
                    default:        ;
                endcase
            end
            if (cmd.idx_clr)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + 1'b1;
            if (cmd.alloc)
            begin
                free_head_reg  <= free_head_reg + 1'b1;
                free_count_reg <= free_count_reg - 1'b1;
            end
            else if (free_push)
                free_count_reg <= free_count_reg + 1'b1;
            if (hot_push)
                hot_count_reg <= hot_count_reg + 1'b1;
            else if (cmd.hot_pop)
            begin
                hot_head_reg  <= hot_head_reg + 1'b1;
                hot_count_reg <= hot_count_reg - 1'b1;
            end
            if (cold_push)
                cold_count_reg <= cold_count_reg + 1'b1;
            else if (cmd.cold_pop)
            begin
                cold_head_reg  <= cold_head_reg + 1'b1;
                cold_count_reg <= cold_count_reg - 1'b1;
            end
            if (cmd.hot_pop)
                from_hot_reg <= 1'b1;
            else if (cmd.cold_pop)
                from_hot_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg        <= opcode;
            bn_reg        <= block_number;
            res_slot_reg  <= '0;
            res_block_reg <= '0;
        end
        else if (cmd.hit_upd)
        begin
            res_slot_reg  <= idx_reg;
            res_block_reg <= bn_reg;
        end
        else if (cmd.alloc)
        begin
            res_slot_reg  <= free_rd_reg;
            res_block_reg <= bn_reg;
        end
        if (cmd.set_status)
            res_status_reg <= cmd.status;
        if (cmd.ent_rd_pop)
            pop_slot_reg <= q_data;
        if (cmd.pop_eval && !rd_acc)
        begin
            ev_slot_reg  <= pop_slot_reg;
            ev_block_reg <= rd_tag;
        end
    end

    assign sts.op         = op_t'(op_reg);
    assign sts.out_range  = bn_reg >= dev_blocks_reg;
    assign sts.match      = rd_valid && (rd_tag == bn_reg);
    assign sts.idx_last   = idx_reg == SLOT_W'(CAPACITY - 1);
    assign sts.free_empty = free_count_reg == '0;
    assign sts.hot_go     = (hot_count_reg != '0) && (hot_share >= hot_thr);
    assign sts.cold_go    = (cold_count_reg != '0) && (cold_share >= cold_thr);
    assign sts.accessed   = rd_acc;

    assign kind         = cmd.sel_ev;
    assign status       = cmd.sel_ev ? ST_W'(ST_HIT) : res_status_reg;
    assign slot         = cmd.sel_ev ? ev_slot_reg : res_slot_reg;
    assign result_block = cmd.sel_ev ? ev_block_reg : res_block_reg;
    assign last         = cmd.out_last;

endmodule

// ----- hdl/tflp_ctrl.sv -----
// Request sequencer of the cache policy unit.
module tflp_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  tflp_pkg::sts_t sts,
    output tflp_pkg::cmd_t cmd
);
    import tflp_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_INIT;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                cmd.init_wr = 1'b1;
                cmd.idx_inc = 1'b1;
                if (sts.idx_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (sts.op == OP_RSVD)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_NOT_FOUND;
                    state_next     = S_OUT_ONE;
                end
                else if (sts.out_range)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_RANGE;
                    state_next     = S_OUT_ONE;
                end
                else
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (sts.match)
                begin
                    cmd.hit_upd    = 1'b1;
                    cmd.set_status = 1'b1;
                    cmd.status     = (sts.op == OP_INVAL) ? ST_INVALIDATED : ST_HIT;
                    state_next     = S_OUT_ONE;
                end
                else if (sts.idx_last)
                begin
                    case (sts.op)
                        OP_ACCESS:
                        begin
                            if (sts.free_empty)
                            begin
                                cmd.set_status = 1'b1;
                                cmd.status     = ST_NO_FREE;
                                state_next     = S_OUT_ONE;
                            end
                            else
                                state_next = S_ALLOC_RD;
                        end
                        OP_INVAL:
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_NOT_PRESENT;
                            state_next     = S_OUT_ONE;
                        end
                        default:
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_NOT_FOUND;
                            state_next     = S_OUT_ONE;
                        end
                    endcase
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end
            S_ALLOC_RD:
            begin
                state_next = S_ALLOC;
            end
            S_ALLOC:
            begin
                cmd.alloc      = 1'b1;
                cmd.set_status = 1'b1;
                cmd.status     = ST_MISS_INS;
                state_next     = S_SHRINK;
            end
            S_SHRINK:
            begin
                if (sts.hot_go)
                begin
                    cmd.hot_pop = 1'b1;
                    state_next  = S_POP_RD;
                end
                else if (sts.cold_go)
                begin
                    cmd.cold_pop = 1'b1;
                    state_next   = S_POP_RD;
                end
                else
                    state_next = S_OUT_ONE;
            end
            S_POP_RD:
            begin
                cmd.ent_rd_pop = 1'b1;
                state_next     = S_POP;
            end
            S_POP:
            begin
                cmd.pop_eval = 1'b1;
                if (sts.accessed)
                    state_next = S_SHRINK;
                else
                    state_next = S_OUT_FIRST;
            end
            S_OUT_ONE:
            begin
                out_valid    = 1'b1;
                cmd.out_last = 1'b1;
                if (out_ready)
                    state_next = S_IDLE;
            end
            S_OUT_FIRST:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = S_OUT_EV;
            end
            S_OUT_EV:
            begin
                out_valid    = 1'b1;
                cmd.sel_ev   = 1'b1;
                cmd.out_last = 1'b1;
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/two_fifo_lazy_promotion_cache_policy_unit.sv -----
// Top level of the two-FIFO lazy-promotion cache policy unit.
// Handles one request at a time. After reset the unit clears the tag store
// and fills the free list before in_ready rises; configuration writes are
// taken during that time. A request with a bad opcode or out of range is
// answered without a tag scan; any other request scans the tag store slot
// by slot until the matching slot is found (all 4096 slots are scanned on
// a miss). An inserting miss then takes a slot from the free list and pops
// queue heads during the shrink. Results follow one per accepted output
// handshake; the status item always comes first and an eviction report,
// when present, second.
`include "two_fifo_lazy_promotion_cache_policy_unit_defines.svh"
module two_fifo_lazy_promotion_cache_policy_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tflp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tflp_pkg::BN_W-1:0]      cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [tflp_pkg::OP_W-1:0]      opcode,
    input  logic [tflp_pkg::BN_W-1:0]      block_number,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           kind,
    output logic [tflp_pkg::ST_W-1:0]      status,
    output logic [tflp_pkg::SLOT_W-1:0]    slot,
    output logic [tflp_pkg::BN_W-1:0]      result_block,
    output logic                           last
);
    import tflp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    tflp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    tflp_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .opcode       (opcode),
        .block_number (block_number),
        .cmd          (cmd),
        .sts          (sts),
        .kind         (kind),
        .status       (status),
        .slot         (slot),
        .result_block (result_block),
        .last         (last)
    );

    `TFLP_ASSERT_IMP(a_ready_no_result, in_ready, !out_valid)
    `TFLP_ASSERT_IMP(a_evict_last, out_valid && kind, last && (status == ST_HIT))
    `TFLP_ASSERT_NXT(a_accept_busy, in_valid && in_ready, !in_ready && !out_valid)
    `TFLP_ASSERT_IMP(a_first_of_two, out_valid && !last, !kind && (status == ST_MISS_INS))

endmodule
